// ===== sv/isck_pkg.sv =====
package isck_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int WIDTH_W = 11;
   localparam int HEIGHT_W = 12;
   localparam int ROW_W   = 12;
   localparam int COL_W   = 10;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT = 1'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type centre;
   } line_entry_type;

   localparam int SUM_W = CHAN_W + 4;

   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] c,
      input logic [CHAN_W-1:0] u,
      input logic [CHAN_W-1:0] d,
      input logic [CHAN_W-1:0] l,
      input logic [CHAN_W-1:0] r
   );
      logic signed [SUM_W-1:0] five_c;
      logic signed [SUM_W-1:0] ring;
      logic signed [SUM_W-1:0] v;
      logic [CHAN_W-1:0]       res;
      five_c = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c});
      ring   = $signed({4'b0000, u}) + $signed({4'b0000, d})
             + $signed({4'b0000, l}) + $signed({4'b0000, r});
      v = five_c - ring;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed(SUM_W'(255))) begin
         res = '1;
      end else begin
         res = v[CHAN_W-1:0];
      end
      return res;
   endfunction

   function automatic pixel_type sharpen_pixel(
      input pixel_type c,
      input pixel_type u,
      input pixel_type d,
      input pixel_type l,
      input pixel_type r
   );
      pixel_type res;
      for (int s = 0; s < 3; s++) begin
         res[s*CHAN_W +: CHAN_W] = sharpen_chan(c[s*CHAN_W +: CHAN_W], u[s*CHAN_W +: CHAN_W],
                                                d[s*CHAN_W +: CHAN_W], l[s*CHAN_W +: CHAN_W],
                                                r[s*CHAN_W +: CHAN_W]);
      end
      return res;
   endfunction

endpackage

// ===== sv/image_sharpen_cross_kernel.sv =====
// Cross-kernel sharpening of an RGB raster stream, one pixel word accepted per clock when no
// result of the word before waits for the output. Each accepted word below the first row
// releases the pixel above it (5*centre minus its four neighbours, clamped, or passed through
// on the frame border), and on the last row also itself. The next word is taken only in the
// cycle in which the last result of the word before enters the output register, so a stalled
// output also stalls the input. The first result of a word enters the output register when
// the output is free, and a second result after it. Both line stores live in one 1024 x 48
// memory with one write and one read per accepted word; the read for the next column is
// fetched ahead. The memory is not cleared after reset.
module image_sharpen_cross_kernel (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [isck_pkg::CHAN_W-1:0]      req_in_red,
   input  logic [isck_pkg::CHAN_W-1:0]      req_in_green,
   input  logic [isck_pkg::CHAN_W-1:0]      req_in_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [isck_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [isck_pkg::COL_W-1:0]       rsp_out_col,
   output logic [isck_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [isck_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [isck_pkg::CHAN_W-1:0]      rsp_out_blue,
   output logic                             rsp_frame_done,
   input  logic                             csr_we,
   input  logic [isck_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [isck_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [isck_pkg::WIDTH_W-1:0]  width_ff;
   logic [isck_pkg::HEIGHT_W-1:0] height_ff;
   logic [isck_pkg::ADDR_W-1:0]   col_ff, col_in;
   logic [isck_pkg::ROW_W-1:0]    row_ff, row_in;

   isck_pkg::line_entry_type line_mem [isck_pkg::MAX_WIDTH];
   isck_pkg::line_entry_type rd_ff;
   isck_pkg::line_entry_type cur_ff;
   isck_pkg::line_entry_type wr_entry;
   isck_pkg::pixel_type      left_ff;
   isck_pkg::pixel_type      px;
   isck_pkg::pixel_type      px_ff;
   isck_pkg::pixel_type      sharp;

   logic [isck_pkg::ROW_W-1:0]  s1_row_ff;
   logic [isck_pkg::ADDR_W-1:0] s1_col_ff;
   logic                        s1_last_col_ff;
   logic                        s1_interior_ff;
   logic                        need_a_ff, need_a_in;
   logic                        need_b_ff, need_b_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [isck_pkg::ROW_W-1:0]  rsp_row_ff;
   logic [isck_pkg::COL_W-1:0]  rsp_col_ff;
   isck_pkg::pixel_type         rsp_pix_ff;
   logic                        rsp_done_ff;

   logic [isck_pkg::WIDTH_W-1:0]  w_eff;
   logic [isck_pkg::HEIGHT_W-1:0] h_eff;
   logic                          last_col, last_row, req_acc;
   logic                          out_free, emit, emit_a, last_emit;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = isck_pkg::WIDTH_W'(1);
      end else if (32'(width_ff) > 32'(isck_pkg::MAX_WIDTH)) begin
         w_eff = isck_pkg::WIDTH_W'(isck_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? isck_pkg::HEIGHT_W'(1) : height_ff;
   end

   assign last_col = (32'(col_ff) + 32'd1) >= 32'(w_eff);
   assign last_row = (32'(row_ff) + 32'd1) >= 32'(h_eff);
   assign col_in   = last_col ? '0 : col_ff + isck_pkg::ADDR_W'(1);
   assign row_in   = last_row ? '0 : row_ff + isck_pkg::ROW_W'(1);
   assign px       = {req_in_red, req_in_green, req_in_blue};
   assign wr_entry = '{upper: rd_ff.centre, centre: px};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (need_a_ff || need_b_ff) && out_free;
   assign emit_a    = need_a_ff;
   assign last_emit = emit && !(need_a_ff && need_b_ff);
   assign req_ready = !(need_a_ff || need_b_ff) || last_emit;
   assign req_acc   = req_valid && req_ready;

   assign sharp = isck_pkg::sharpen_pixel(cur_ff.centre, cur_ff.upper, px_ff, left_ff,
                                          rd_ff.centre);

   always_comb begin
      need_a_in = need_a_ff;
      need_b_in = need_b_ff;
      if (emit) begin
         if (emit_a) begin
            need_a_in = 1'b0;
         end else begin
            need_b_in = 1'b0;
         end
      end
      if (req_acc) begin
         need_a_in = (row_ff != '0);
         need_b_in = last_row;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= isck_pkg::WIDTH_RESET;
         height_ff    <= isck_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         need_a_ff    <= 1'b0;
         need_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               isck_pkg::CSR_IMG_WIDTH:  width_ff  <= csr_wdata[isck_pkg::WIDTH_W-1:0];
               isck_pkg::CSR_IMG_HEIGHT: height_ff <= csr_wdata[isck_pkg::HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            col_ff <= col_in;
            if (last_col) begin
               row_ff <= row_in;
            end
         end
         need_a_ff    <= need_a_in;
         need_b_ff    <= need_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The entry for the next column is read ahead; with a one-pixel row it is the one written now.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         line_mem[col_ff] <= wr_entry;
         rd_ff            <= (col_in == col_ff) ? wr_entry : line_mem[col_in];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cur_ff         <= rd_ff;
         left_ff        <= cur_ff.centre;
         px_ff          <= px;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_col_ff <= last_col;
         s1_interior_ff <= (row_ff > isck_pkg::ROW_W'(1)) && (col_ff != '0) && !last_col;
      end
      if (emit) begin
         rsp_col_ff <= isck_pkg::COL_W'(s1_col_ff);
         if (emit_a) begin
            rsp_row_ff  <= s1_row_ff - isck_pkg::ROW_W'(1);
            rsp_pix_ff  <= s1_interior_ff ? sharp : cur_ff.centre;
            rsp_done_ff <= 1'b0;
         end else begin
            rsp_row_ff  <= s1_row_ff;
            rsp_pix_ff  <= px_ff;
            rsp_done_ff <= s1_last_col_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_red    = rsp_pix_ff[2*isck_pkg::CHAN_W +: isck_pkg::CHAN_W];
   assign rsp_out_green  = rsp_pix_ff[isck_pkg::CHAN_W +: isck_pkg::CHAN_W];
   assign rsp_out_blue   = rsp_pix_ff[0 +: isck_pkg::CHAN_W];
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ===== sv/isck_checker.sv =====
module isck_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [isck_pkg::ROW_W-1:0]       rsp_out_row,
   input logic [isck_pkg::COL_W-1:0]       rsp_out_col,
   input logic [isck_pkg::CHAN_W-1:0]      rsp_out_red,
   input logic [isck_pkg::CHAN_W-1:0]      rsp_out_green,
   input logic [isck_pkg::CHAN_W-1:0]      rsp_out_blue,
   input logic                             rsp_frame_done
);

   // A stalled result word keeps its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_frame_done))
      else $error("result word changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The word after the end of a frame belongs to the first row of the next frame.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_done |=> !rsp_valid || rsp_out_row == '0)
      else $error("frame did not restart at row zero");

endmodule

bind image_sharpen_cross_kernel isck_checker u_isck_checker (.*);
